### rtl/core/hbm_pkg.sv
`default_nettype none

package hbm_pkg;

   // Store sizes (bytes)
   localparam int HBM_INTERNAL_BYTES = 32768;
   localparam int HBM_CART_RAM_BYTES = 32768;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAPPER_KIND = 1'b0,
      CSR_CART_RAM    = 1'b1
   } csr_idx_type;

   // Mapper kinds
   localparam logic [1:0] MAPPER_NONE = 2'd0;
   localparam logic [1:0] MAPPER_MBC1 = 2'd1;
   localparam logic [1:0] MAPPER_MBC2 = 2'd2;

   // Transaction targets
   typedef enum logic [2:0] {
      TGT_ROM      = 3'd0,
      TGT_INTERNAL = 3'd1,
      TGT_CART_RAM = 3'd2,
      TGT_SOUND    = 3'd3,
      TGT_DMA      = 3'd4,
      TGT_MAPPER   = 3'd5
   } tgt_type;

   // Source of the returned read byte
   typedef enum logic [1:0] {
      SEL_NONE     = 2'd0,
      SEL_INTERNAL = 2'd1,
      SEL_CART     = 2'd2
   } rd_sel_type;

   // Controller state
   typedef enum logic {
      ST_CLEAR = 1'b0,
      ST_RUN   = 1'b1
   } hbm_state_type;

   // Bus map
   localparam logic [15:0] ADDR_ROM0_END   = 16'h3FFF;
   localparam logic [15:0] ADDR_ROMX_END   = 16'h7FFF;
   localparam logic [15:0] ADDR_VRAM_BASE  = 16'h8000;
   localparam logic [15:0] ADDR_VRAM_END   = 16'h9FFF;
   localparam logic [15:0] ADDR_CRAM_BASE  = 16'hA000;
   localparam logic [15:0] ADDR_CRAM_END   = 16'hBFFF;
   localparam logic [15:0] ADDR_BANK_BASE  = 16'h2000;
   localparam logic [15:0] ADDR_BANK_END   = 16'h3FFF;
   localparam logic [15:0] ADDR_RBANK_BASE = 16'h4000;
   localparam logic [15:0] ADDR_RBANK_END  = 16'h5FFF;
   localparam logic [15:0] ADDR_SOUND_LO   = 16'hFF10;
   localparam logic [15:0] ADDR_SOUND_HI   = 16'hFF26;
   localparam logic [15:0] ADDR_DMA        = 16'hFF46;

   // Size of one cartridge RAM bank
   localparam int CART_BANK_BYTES = 8192;

endpackage

`default_nettype wire

### rtl/core/hbm_ram.sv
`default_nettype none

module hbm_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             write_enable,
   input  wire logic [AW-1:0]    write_address,
   input  wire logic [WIDTH-1:0] write_data,
   input  wire logic [AW-1:0]    read_address,
   output logic      [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data <= mem[read_address];
   end

endmodule

`default_nettype wire

### rtl/core/handheld_bus_map_with_mbc_banking.sv
`default_nettype none

// Bus decoder and bank controller for one 16-bit CPU bus access per transaction. After reset
// the internal store is swept to zero, one byte a cycle, and busy stays high until all
// INTERNAL_BYTES bytes are zero; configuration writes are taken during the sweep. From then on a
// transaction is accepted every cycle and its result appears on the rsp_ ports, strobed by
// rsp_valid, in the cycle after acceptance, a latency set by the registered read of the
// store memories. A bank register write is seen by the very next transaction. The receiver
// cannot stall: each result is shown for exactly one cycle.
module handheld_bus_map_with_mbc_banking
   import hbm_pkg::*;
#(
   parameter int INTERNAL_BYTES = HBM_INTERNAL_BYTES,
   parameter int CART_RAM_BYTES = HBM_CART_RAM_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_action,
   input  wire logic [15:0]           req_bus_address,
   input  wire logic [7:0]            req_write_byte,
   // Result
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_read_byte,
   output logic [2:0]                 rsp_target,
   output logic [18:0]                rsp_rom_byte_address,
   output logic [7:0]                 rsp_dma_page,
   // Configuration
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int INT_AW  = $clog2(INTERNAL_BYTES);
   localparam int CART_AW = $clog2(CART_RAM_BYTES);

   // Bank base offsets, already reduced modulo the cart RAM size
   localparam int CART_BASE1 = (1 * CART_BANK_BYTES) % CART_RAM_BYTES;
   localparam int CART_BASE2 = (2 * CART_BANK_BYTES) % CART_RAM_BYTES;
   localparam int CART_BASE3 = (3 * CART_BANK_BYTES) % CART_RAM_BYTES;

   // Control state
   hbm_state_type      state_ff, state_in;
   logic [INT_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [1:0]         mapper_kind_ff;
   logic               cart_present_ff;
   logic [4:0]         rom_bank_ff, rom_bank_in;
   logic [1:0]         ram_bank_ff, ram_bank_in;

   // Result registers
   logic               rsp_valid_ff;
   tgt_type            tgt_ff, tgt_in;
   logic [18:0]        rom_ff, rom_in;
   logic [7:0]         page_ff, page_in;
   rd_sel_type         rd_sel_ff, rd_sel_in;

   // Decode
   logic               accept;
   logic               a_vram, a_cram, a_sound, a_dma, a_low, a_bank, a_rbank;
   logic [15:0]        int_off;
   logic [INT_AW-1:0]  int_idx;
   logic [1:0]         cart_bank;
   logic [15:0]        cart_base, cart_sum;
   logic [CART_AW-1:0] cart_idx;
   logic               clr_we;
   logic               int_we, cart_we;
   logic [INT_AW-1:0]  int_waddr;
   logic [7:0]         int_wdata;
   logic [7:0]         int_q, cart_q;
   logic [4:0]         bank_sel;

   assign accept = start && !busy;

   // Address ranges
   always_comb begin
      a_low   = req_bus_address <= ADDR_ROMX_END;
      a_vram  = req_bus_address >= ADDR_VRAM_BASE && req_bus_address <= ADDR_VRAM_END;
      a_cram  = req_bus_address >= ADDR_CRAM_BASE && req_bus_address <= ADDR_CRAM_END;
      a_sound = req_bus_address >= ADDR_SOUND_LO && req_bus_address <= ADDR_SOUND_HI;
      a_dma   = req_bus_address == ADDR_DMA;
      a_bank  = req_bus_address >= ADDR_BANK_BASE && req_bus_address <= ADDR_BANK_END;
      a_rbank = req_bus_address >= ADDR_RBANK_BASE && req_bus_address <= ADDR_RBANK_END;
   end

   // Internal store index; internal addresses all lie at or above 0x8000, so the
   // offset stays below 0x6000 and never wraps
   always_comb begin
      int_off = a_vram ? (req_bus_address - ADDR_VRAM_BASE)
                       : (req_bus_address - ADDR_CRAM_BASE);
      int_idx = int_off[INT_AW-1:0];
   end

   // Cart RAM index: bank base plus offset, one conditional subtract for the wrap
   always_comb begin
      cart_bank = (req_action && mapper_kind_ff == MAPPER_MBC2) ? 2'd0 : ram_bank_ff;
      case (cart_bank)
         2'd1:    cart_base = 16'(CART_BASE1);
         2'd2:    cart_base = 16'(CART_BASE2);
         2'd3:    cart_base = 16'(CART_BASE3);
         default: cart_base = 16'd0;
      endcase
      cart_sum = cart_base + {3'd0, req_bus_address[12:0]};
      if (cart_sum >= 16'(CART_RAM_BYTES)) begin
         cart_sum = cart_sum - 16'(CART_RAM_BYTES);
      end
      cart_idx = cart_sum[CART_AW-1:0];
   end

   // Transaction decode, bank register updates and store writes
   always_comb begin
      tgt_in      = TGT_INTERNAL;
      rom_in      = 19'd0;
      page_in     = 8'd0;
      rd_sel_in   = SEL_NONE;
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      int_we      = 1'b0;
      cart_we     = 1'b0;
      bank_sel    = (mapper_kind_ff == MAPPER_MBC2) ? {1'b0, req_write_byte[3:0]}
                                                   : req_write_byte[4:0];
      if (!req_action) begin
         if (req_bus_address <= ADDR_ROM0_END) begin
            tgt_in = TGT_ROM;
            rom_in = {3'd0, req_bus_address};
         end else if (a_low) begin
            tgt_in = TGT_ROM;
            rom_in = {rom_bank_ff, req_bus_address[13:0]};
         end else if (a_cram && cart_present_ff) begin
            tgt_in    = TGT_CART_RAM;
            rd_sel_in = SEL_CART;
         end else begin
            rd_sel_in = SEL_INTERNAL;
         end
      end else begin
         if (a_low) begin
            tgt_in = TGT_MAPPER;
            if (mapper_kind_ff == MAPPER_MBC1 || mapper_kind_ff == MAPPER_MBC2) begin
               if (a_bank) begin
                  rom_bank_in = (bank_sel == 5'd0) ? 5'd1 : bank_sel;
               end else if (a_rbank && mapper_kind_ff == MAPPER_MBC1) begin
                  ram_bank_in = req_write_byte[6:5];
               end
            end
         end else if (a_cram) begin
            tgt_in  = TGT_CART_RAM;
            cart_we = (mapper_kind_ff == MAPPER_MBC1 && cart_present_ff)
                      || mapper_kind_ff == MAPPER_MBC2;
         end else if (a_sound) begin
            tgt_in = TGT_SOUND;
         end else if (a_dma) begin
            tgt_in  = TGT_DMA;
            page_in = req_write_byte;
         end else begin
            int_we = 1'b1;
         end
      end
   end

   // Clearing sweep and next state
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_we     = 1'b0;
      busy       = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            busy       = 1'b1;
            clr_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + INT_AW'(1);
            if (clr_cnt_ff == INT_AW'(INTERNAL_BYTES - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            busy = 1'b0;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Internal store write port is shared with the sweep
   always_comb begin
      int_waddr = clr_we ? clr_cnt_ff : int_idx;
      int_wdata = clr_we ? 8'd0 : req_write_byte;
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Configuration and bank registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mapper_kind_ff  <= MAPPER_MBC1;
         cart_present_ff <= 1'b0;
         rom_bank_ff     <= 5'd1;
         ram_bank_ff     <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_MAPPER_KIND: mapper_kind_ff  <= csr_write_data;
               CSR_CART_RAM:    cart_present_ff <= csr_write_data[0];
               default:         ;
            endcase
         end
         if (accept) begin
            rom_bank_ff <= rom_bank_in;
            ram_bank_ff <= ram_bank_in;
         end
      end
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         tgt_ff    <= tgt_in;
         rom_ff    <= rom_in;
         page_ff   <= page_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   // Store memories
   hbm_ram #(
      .WIDTH (8),
      .DEPTH (INTERNAL_BYTES)
   ) u_internal_ram (
      .clock         (clock),
      .write_enable  (clr_we || (accept && int_we)),
      .write_address (int_waddr),
      .write_data    (int_wdata),
      .read_address  (int_idx),
      .read_data     (int_q)
   );

   hbm_ram #(
      .WIDTH (8),
      .DEPTH (CART_RAM_BYTES)
   ) u_cart_ram (
      .clock         (clock),
      .write_enable  (accept && cart_we),
      .write_address (cart_idx),
      .write_data    (req_write_byte),
      .read_address  (cart_idx),
      .read_data     (cart_q)
   );

   // Outputs
   always_comb begin
      case (rd_sel_ff)
         SEL_INTERNAL: rsp_read_byte = int_q;
         SEL_CART:     rsp_read_byte = cart_q;
         default:      rsp_read_byte = 8'd0;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_target           = tgt_ff;
   assign rsp_rom_byte_address = rom_ff;
   assign rsp_dma_page         = page_ff;

   // Checks
   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept))
      else $error("result strobe without an accepted transaction");

   a_rom_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rom_bank_ff != 5'd0)
      else $error("ROM bank register holds zero");

   a_mbc2_bank_narrow: assert property (@(posedge clock) disable iff (reset)
      accept && req_action && a_bank && mapper_kind_ff == MAPPER_MBC2
      |=> rom_bank_ff[4] == 1'b0)
      else $error("MBC2 bank write set the top bank bit");

   a_rom_addr_only_rom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tgt_ff != TGT_ROM |-> rom_ff == 19'd0)
      else $error("ROM address on a non-ROM result");

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> !rsp_valid_ff)
      else $error("transaction accepted during the clearing sweep");

endmodule

`default_nettype wire
